### hdl/masked_column_pattern_detector_defines.svh
// ----------------------------------------------------------------------------
// Masked column pattern detector assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MASKED_COLUMN_PATTERN_DETECTOR_DEFINES_SVH
`define MASKED_COLUMN_PATTERN_DETECTOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MCPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MCPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/mcpd_pkg.sv
// ----------------------------------------------------------------------------
// mcpd_pkg
// Widths, defaults, register indexes and cell control type of the detector.
// ----------------------------------------------------------------------------
package mcpd_pkg;

	localparam int COL_W         = 3;
	localparam int ROW_REG_W     = 16;
	localparam int NUM_ROW_REGS  = 3;
	localparam int LEN_W         = 5;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int ROWS_DEF      = 3;
	localparam int MAX_POS_DEF   = 16;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MASK_ROW_0     = 3'd0,
		REG_MASK_ROW_1     = 3'd1,
		REG_MASK_ROW_2     = 3'd2,
		REG_WANT_ROW_0     = 3'd3,
		REG_WANT_ROW_1     = 3'd4,
		REG_WANT_ROW_2     = 3'd5,
		REG_PATTERN_LENGTH = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic step;
		logic restart;
		logic in_range;
		logic is_last;
	} cell_ctl_t;

endpackage

### hdl/mcpd_cfg.sv
// ----------------------------------------------------------------------------
// mcpd_cfg
// Configuration registers, per-position mask and want words, clamped length.
// ----------------------------------------------------------------------------
module mcpd_cfg #(
	parameter int ROWS          = mcpd_pkg::ROWS_DEF,
	parameter int MAX_POSITIONS = mcpd_pkg::MAX_POS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [mcpd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [mcpd_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic [MAX_POSITIONS-1:0][ROWS-1:0]     pos_mask,
	output logic [MAX_POSITIONS-1:0][ROWS-1:0]     pos_want,
	output logic [mcpd_pkg::LEN_W-1:0]             len_sat
);

	logic [mcpd_pkg::ROW_REG_W-1:0] mask_q [mcpd_pkg::NUM_ROW_REGS];
	logic [mcpd_pkg::ROW_REG_W-1:0] want_q [mcpd_pkg::NUM_ROW_REGS];
	logic [mcpd_pkg::LEN_W-1:0]     length_q;
	mcpd_pkg::cfg_reg_t             reg_sel;

	assign reg_sel = mcpd_pkg::cfg_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < mcpd_pkg::NUM_ROW_REGS; j++) begin
				mask_q[j] <= '0;
				want_q[j] <= '0;
			end
			length_q <= mcpd_pkg::LEN_RESET;
		end else if (cfg_we) begin
			case (reg_sel)
				mcpd_pkg::REG_MASK_ROW_0:     mask_q[0] <= cfg_data;
				mcpd_pkg::REG_MASK_ROW_1:     mask_q[1] <= cfg_data;
				mcpd_pkg::REG_MASK_ROW_2:     mask_q[2] <= cfg_data;
				mcpd_pkg::REG_WANT_ROW_0:     want_q[0] <= cfg_data;
				mcpd_pkg::REG_WANT_ROW_1:     want_q[1] <= cfg_data;
				mcpd_pkg::REG_WANT_ROW_2:     want_q[2] <= cfg_data;
				mcpd_pkg::REG_PATTERN_LENGTH: length_q  <= cfg_data[mcpd_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < MAX_POSITIONS; i++) begin : g_pos
		for (genvar j = 0; j < ROWS; j++) begin : g_row
			if (i < mcpd_pkg::ROW_REG_W) begin : g_bit
				assign pos_mask[i][j] = mask_q[j][i];
				assign pos_want[i][j] = want_q[j][i];
			end else begin : g_zero
				assign pos_mask[i][j] = 1'b0;
				assign pos_want[i][j] = 1'b0;
			end
		end
	end

	assign len_sat = (length_q > mcpd_pkg::LEN_W'(MAX_POSITIONS)) ?
		mcpd_pkg::LEN_W'(MAX_POSITIONS) : length_q;

endmodule

### hdl/mcpd_cell.sv
// ----------------------------------------------------------------------------
// mcpd_cell
// One pattern position: holds its active bit and tests the column against it.
// ----------------------------------------------------------------------------
module mcpd_cell #(
	parameter int ROWS    = mcpd_pkg::ROWS_DEF,
	parameter bit IS_HEAD = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mcpd_pkg::cell_ctl_t   ctl,
	input  logic [ROWS-1:0]       column,
	input  logic [ROWS-1:0]       mask,
	input  logic [ROWS-1:0]       want,
	input  logic                  carry_in,
	output logic                  carry_out,
	output logic                  hit,
	output logic                  active
);

	logic active_q;
	logic active_cur;

	assign active_cur = ctl.restart ? IS_HEAD : active_q;
	assign carry_out  = active_cur & ctl.in_range & ((column & mask) == want);
	assign hit        = carry_out & ctl.is_last;
	assign active     = active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= IS_HEAD;
		end else if (ctl.step) begin
			active_q <= IS_HEAD | (carry_in & ctl.in_range);
		end
	end

endmodule

### hdl/masked_column_pattern_detector.sv
// ----------------------------------------------------------------------------
// masked_column_pattern_detector
// Shift-and matcher of a masked column pattern with a sticky found flag.
// ----------------------------------------------------------------------------
// Channel   Handshake               Beat contents
// in        in_valid / in_ready     column, restart
// out       out_valid / out_ready   found, active_positions
// cfg       cfg_we                  cfg_index, cfg_data
//
// One beat is taken per cycle while in_ready is high; its result is ready in the cycle after.
// Each position cell updates its active bit in the same cycle from its left
// neighbor, so the column rate is set by a single cell compare.
// A new beat is taken while the result register is empty or being drained.
// After reset only position 0 is active and found is clear.
// ----------------------------------------------------------------------------
module masked_column_pattern_detector #(
	parameter int ROWS          = mcpd_pkg::ROWS_DEF,
	parameter int MAX_POSITIONS = mcpd_pkg::MAX_POS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [mcpd_pkg::COL_W-1:0]        column,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic [MAX_POSITIONS-1:0]          active_positions,
	input  logic                              cfg_we,
	input  logic [mcpd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mcpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

	`include "masked_column_pattern_detector_defines.svh"

	logic [MAX_POSITIONS-1:0][ROWS-1:0] pos_mask;
	logic [MAX_POSITIONS-1:0][ROWS-1:0] pos_want;
	logic [mcpd_pkg::LEN_W-1:0]         len_sat;
	logic [MAX_POSITIONS-1:0]           carry;
	logic [MAX_POSITIONS-1:0]           hits;
	logic                               step;
	logic                               out_valid_q;
	logic                               found_q;

	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	mcpd_cfg #(
		.ROWS          (ROWS),
		.MAX_POSITIONS (MAX_POSITIONS)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pos_mask  (pos_mask),
		.pos_want  (pos_want),
		.len_sat   (len_sat)
	);

	for (genvar i = 0; i < MAX_POSITIONS; i++) begin : g_cell
		mcpd_pkg::cell_ctl_t ctl;
		logic                carry_prev;

		assign ctl.step     = step;
		assign ctl.restart  = restart;
		assign ctl.in_range = len_sat > mcpd_pkg::LEN_W'(i);
		assign ctl.is_last  = len_sat == mcpd_pkg::LEN_W'(i + 1);

		if (i == 0) begin : g_head
			assign carry_prev = 1'b1;
		end else begin : g_body
			assign carry_prev = carry[i-1];
		end

		mcpd_cell #(
			.ROWS    (ROWS),
			.IS_HEAD (i == 0)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.column    (column[ROWS-1:0]),
			.mask      (pos_mask[i]),
			.want      (pos_want[i]),
			.carry_in  (carry_prev),
			.carry_out (carry[i]),
			.hit       (hits[i]),
			.active    (active_positions[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				found_q <= (found_q && !restart) || (len_sat == '0) || (|hits);
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;

	`MCPD_ASSERT_NOW(a_head_active, 1'b1, active_positions[0],
		"position 0 is not active")
	`MCPD_ASSERT_NEXT(a_found_sticky, found_q && !(step && restart), found_q,
		"found cleared without a restart")
	`MCPD_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready,
		"input stalled with an empty result register")
	`MCPD_ASSERT_NEXT(a_result_follows, step, out_valid_q,
		"accepted beat produced no result")

endmodule

### verif/mcpd_match_monitor.sv
// ----------------------------------------------------------------------------
// mcpd_match_monitor
// Watches the column, result and register ports of the masked column pattern
// detector. It keeps its own copy of the pattern registers and the matcher
// state, predicts found and active_positions for every accepted column beat,
// and compares each result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module mcpd_match_monitor
	import mcpd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [COL_W-1:0]       column,
	input  logic                   restart,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic                   found,
	input  logic [MAX_POS_DEF-1:0] active_positions,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatches,
	output int                     pending,
	output int                     compared,
	output int                     found_results
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                   found;
		logic [MAX_POS_DEF-1:0] active;
	} match_state_t;

	logic [ROW_REG_W-1:0]   care_row [NUM_ROW_REGS];
	logic [ROW_REG_W-1:0]   want_row [NUM_ROW_REGS];
	logic [LEN_W-1:0]       pat_len;
	logic [MAX_POS_DEF-1:0] live_prefixes;
	logic                   seen_match;
	match_state_t           awaited_states [$];
	int                     err_count;
	int                     cmp_count;
	int                     found_count;

	function automatic match_state_t advance_prefixes(input logic [COL_W-1:0] col,
			input logic clear);
		int                   span;
		logic [MAX_POS_DEF:0] nxt;
		logic [COL_W-1:0]     care;
		logic [COL_W-1:0]     want;
		match_state_t         res;
		if (clear) begin
			live_prefixes = MAX_POS_DEF'(1);
			seen_match    = 1'b0;
		end
		span = (pat_len > MAX_POS_DEF) ? MAX_POS_DEF : int'(pat_len);
		nxt  = (MAX_POS_DEF+1)'(1);
		for (int i = 0; i < span; i++) begin
			if (live_prefixes[i]) begin
				for (int j = 0; j < NUM_ROW_REGS; j++) begin
					care[j] = care_row[j][i];
					want[j] = want_row[j][i];
				end
				if ((col & care) == want)
					nxt[i+1] = 1'b1;
			end
		end
		if (nxt[span])
			seen_match = 1'b1;
		live_prefixes = (nxt[MAX_POS_DEF-1:0] & ~({MAX_POS_DEF{1'b1}} << span))
			| MAX_POS_DEF'(1);
		res.found  = seen_match;
		res.active = live_prefixes;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_state_t due;
		if (!arst_n) begin
			for (int j = 0; j < NUM_ROW_REGS; j++) begin
				care_row[j] = '0;
				want_row[j] = '0;
			end
			pat_len       = LEN_RESET;
			live_prefixes = MAX_POS_DEF'(1);
			seen_match    = 1'b0;
			awaited_states.delete();
			err_count     = 0;
			cmp_count     = 0;
			found_count   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_states.size() == 0) begin
					$display("%0t: result beat with nothing expected: found %0b active %h",
						$time, found, active_positions);
					err_count++;
				end else begin
					due = awaited_states.pop_front();
					cmp_count++;
					if (found)
						found_count++;
					if (found !== due.found) begin
						$display("%0t: found expected %0b actual %0b",
							$time, due.found, found);
						err_count++;
					end
					if (active_positions !== due.active) begin
						$display("%0t: active_positions expected %h actual %h",
							$time, due.active, active_positions);
						err_count++;
					end
				end
			end
			if (in_valid && in_ready)
				awaited_states = {awaited_states, advance_prefixes(column, restart)};
			if (cfg_we) begin
				case (cfg_index)
					REG_MASK_ROW_0:     care_row[0] = cfg_data;
					REG_MASK_ROW_1:     care_row[1] = cfg_data;
					REG_MASK_ROW_2:     care_row[2] = cfg_data;
					REG_WANT_ROW_0:     want_row[0] = cfg_data;
					REG_WANT_ROW_1:     want_row[1] = cfg_data;
					REG_WANT_ROW_2:     want_row[2] = cfg_data;
					REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
		end
		mismatches    <= err_count;
		pending       <= awaited_states.size();
		compared      <= cmp_count;
		found_results <= found_count;
	end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the masked column pattern detector. A short
// directed part walks the default pattern, a full sixteen-position pattern,
// a zero length and an oversized length; random phases then program new
// patterns and feed mostly pattern prefixes with noise and restarts mixed in,
// while the sender bursts and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mcpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BEATS = 1500;
	localparam int PHASES       = 12;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} drain_mode_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   in_valid  = 1'b0;
	logic                   in_ready;
	logic [COL_W-1:0]       column    = '0;
	logic                   restart   = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   found;
	logic [MAX_POS_DEF-1:0] active_positions;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int mismatches;
	int pending;
	int compared;
	int found_results;

	logic [ROW_REG_W-1:0] cur_care [NUM_ROW_REGS];
	logic [ROW_REG_W-1:0] cur_want [NUM_ROW_REGS];
	logic [LEN_W-1:0]     cur_len;
	logic [COL_W-1:0]     walk [MAX_POS_DEF];

	int          burst_left    = 0;
	int          beats_sent    = 0;
	int          restarts_sent = 0;
	int          settings      = 0;
	int          cycle_count   = 0;
	drain_mode_t drain_mode    = RX_OPEN;
	int          drain_left    = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	masked_column_pattern_detector DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.column           (column),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.found            (found),
		.active_positions (active_positions),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	mcpd_match_monitor u_monitor (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.column           (column),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.found            (found),
		.active_positions (active_positions),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatches       (mismatches),
		.pending          (pending),
		.compared         (compared),
		.found_results    (found_results)
	);

	always @(posedge clk) begin
		if (drain_left == 0) begin
			drain_mode <= drain_mode_t'($urandom_range(0, 3));
			drain_left <= $urandom_range(16, 200);
		end else begin
			drain_left <= drain_left - 1;
		end
		case (drain_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
			RX_TOGGLE: out_ready <= ~out_ready;
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("masked_column_pattern_detector test failed");
			$finish;
		end
	end

	task automatic send_beat(input logic [COL_W-1:0] col, input logic clear);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		column   <= col;
		restart  <= clear;
		do @(posedge clk); while (!in_ready);
		beats_sent++;
		if (clear)
			restarts_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic program_pattern();
		write_reg(REG_MASK_ROW_0, cur_care[0]);
		write_reg(REG_MASK_ROW_1, cur_care[1]);
		write_reg(REG_MASK_ROW_2, cur_care[2]);
		write_reg(REG_WANT_ROW_0, cur_want[0]);
		write_reg(REG_WANT_ROW_1, cur_want[1]);
		write_reg(REG_WANT_ROW_2, cur_want[2]);
		write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(cur_len));
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	function automatic logic [COL_W-1:0] pattern_column(input int pos);
		logic [COL_W-1:0] c;
		c = COL_W'($urandom);
		for (int j = 0; j < NUM_ROW_REGS; j++)
			if (cur_care[j][pos])
				c[j] = cur_want[j][pos];
		return c;
	endfunction

	task automatic random_phase(input int beats);
		int pick;
		int span;
		int run;
		int sent;
		pick = $urandom_range(0, 9);
		case (pick)
			0:       cur_len = '0;
			1:       cur_len = LEN_W'(MAX_POS_DEF);
			2:       cur_len = LEN_W'($urandom_range(MAX_POS_DEF + 1, 31));
			default: cur_len = LEN_W'($urandom_range(1, 6));
		endcase
		for (int j = 0; j < NUM_ROW_REGS; j++) begin
			pick = $urandom_range(0, 7);
			cur_care[j] = (pick == 0) ? '0 : (pick == 1) ? '1 : ROW_REG_W'($urandom);
			if ($urandom_range(0, 3) == 0)
				cur_want[j] = ROW_REG_W'($urandom);
			else
				cur_want[j] = ROW_REG_W'($urandom) & cur_care[j];
		end
		settle();
		program_pattern();
		span = (cur_len > MAX_POS_DEF) ? MAX_POS_DEF : int'(cur_len);
		sent = 0;
		while (sent < beats) begin
			if (span > 0 && $urandom_range(0, 9) < 7) begin
				run = $urandom_range(1, span + 2);
				for (int k = 0; k < run; k++) begin
					send_beat((k < span) ? pattern_column(k) : COL_W'($urandom),
						(k == 0) && ($urandom_range(0, 3) == 0));
					sent++;
				end
			end else begin
				send_beat(COL_W'($urandom), $urandom_range(0, 15) == 0);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset registers, one position with no care bits matches any column.
		send_beat('0, 1'b0);
		send_beat('1, 1'b1);
		send_beat('1, 1'b0);

		for (int i = 0; i < MAX_POS_DEF; i++)
			walk[i] = COL_W'(i * 5 + 3);
		for (int j = 0; j < NUM_ROW_REGS; j++) begin
			cur_care[j] = '1;
			for (int i = 0; i < MAX_POS_DEF; i++)
				cur_want[j][i] = walk[i][j];
		end
		cur_len = LEN_W'(MAX_POS_DEF);
		settle();
		program_pattern();
		send_beat(walk[0], 1'b1);
		for (int i = 1; i < MAX_POS_DEF; i++)
			send_beat(walk[i], 1'b0);
		send_beat('0, 1'b0);

		cur_len = '0;
		settle();
		program_pattern();
		send_beat(COL_W'(5), 1'b1);
		send_beat(COL_W'(2), 1'b0);

		for (int j = 0; j < NUM_ROW_REGS; j++) begin
			cur_care[j] = '0;
			cur_want[j] = '0;
		end
		cur_len = '1;
		settle();
		program_pattern();
		send_beat(COL_W'(6), 1'b1);
		send_beat(COL_W'(1), 1'b0);
		send_beat(COL_W'(4), 1'b0);

		for (int p = 0; p < PHASES; p++)
			random_phase(RANDOM_BEATS / PHASES);

		settle();
		$display("Run covered %0d column beats, %0d of them with restart, under %0d register settings.",
			beats_sent, restarts_sent, settings);
		$display("%0d result beats were compared, %0d of them with found set.",
			compared, found_results);
		if (mismatches == 0) begin
			$display("masked_column_pattern_detector test passed");
		end else begin
			$display("masked_column_pattern_detector test failed");
		end
		$finish;
	end

endmodule
